>>> design/lt7_pkg.sv
// shared types and constants of the layer-7 latency tracker
package lt7_pkg;

   localparam int KEY_W         = 64;
   localparam int REQ_DATA_W    = 90;
   localparam int DST_DATA_W    = 48;
   localparam int PAYLOAD_LIMIT = 512;
   localparam int LEN_W         = 9;
   localparam logic [31:0] MIN_SNIFF   = 32'd16;
   localparam logic [7:0]  QR_BIT      = 8'b1000_0000;
   localparam logic [7:0]  OPCODE_BITS = 8'b0111_1000;
   localparam logic [7:0]  RCODE_BITS  = 8'b0000_1111;

   // request word layout in the request table
   localparam int RD_TIME_LO  = 0;
   localparam int RD_PROTO    = 64;
   localparam int RD_TXN_LO   = 65;
   localparam int RD_LEN_LO   = 81;

   typedef enum logic [1:0] {
      CMD_REQUEST  = 2'd0,
      CMD_RESPONSE = 2'd1,
      CMD_CONNECT  = 2'd2,
      CMD_UNUSED   = 2'd3
   } lt7_cmd_type;

   typedef enum logic {
      PROTO_HTTP = 1'b0,
      PROTO_DNS  = 1'b1
   } lt7_proto_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_TOUCH  = 2'd2,
      OP_RETIRE = 2'd3
   } lt7_op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOK   = 2'd1,
      ST_UPDATE = 2'd2
   } lt7_state_type;

   typedef struct packed {
      logic        http_req;
      logic        dns_query;
      logic        http_resp;
      logic        dns_resp;
      logic [15:0] txn;
      logic [9:0]  http_status;
      logic [3:0]  rcode;
   } lt7_sniff_type;

endpackage

>>> design/lt7_cell.sv
// one table entry: key compare, lru age and stored word, chained to its neighbor
module lt7_cell #(
   parameter int ENTRIES = 64,
   parameter int INDEX   = 0,
   parameter int DATA_W  = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lt7_pkg::lt7_op_type                   op_i,
   input  logic [$clog2(ENTRIES)-1:0]            tgt_age_i,
   input  logic [lt7_pkg::KEY_W-1:0]             key_i,
   input  logic [DATA_W-1:0]                     wdata_i,
   input  logic                                  hit_in,
   input  logic [$clog2(ENTRIES)-1:0]            age_in,
   input  logic [DATA_W-1:0]                     data_in,
   output logic                                  hit_out,
   output logic [$clog2(ENTRIES)-1:0]            age_out,
   output logic [DATA_W-1:0]                     data_out
);
   import lt7_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_AGE  = IDX_W'(ENTRIES - 1);
   localparam logic [IDX_W-1:0] RESET_AGE = IDX_W'(INDEX);

   logic              valid_ff;
   logic [IDX_W-1:0]  age_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_ff;
   logic              hit;
   logic              sel;

   // associative compare, merged into the chain
   assign hit      = valid_ff && (key_ff == key_i);
   assign sel      = (age_ff == tgt_age_i);
   assign hit_out  = hit_in | hit;
   assign age_out  = age_in | (hit ? age_ff : '0);
   assign data_out = data_in | (hit ? data_ff : '0);

   // valid bit and lru age
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= RESET_AGE;
      end else begin
         case (op_i)
            OP_WRITE, OP_TOUCH: begin
               if (sel) begin
                  age_ff <= '0;
                  if (op_i == OP_WRITE) valid_ff <= 1'b1;
               end else if (age_ff < tgt_age_i) begin
                  age_ff <= age_ff + 1'b1;
               end
            end
            OP_RETIRE: begin
               if (sel) begin
                  age_ff   <= LAST_AGE;
                  valid_ff <= 1'b0;
               end else if (age_ff > tgt_age_i) begin
                  age_ff <= age_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // key and stored word
   always_ff @(posedge clock) begin
      if ((op_i == OP_WRITE) && sel) begin
         key_ff  <= key_i;
         data_ff <= wdata_i;
      end
   end

endmodule

>>> design/lt7_sniff.sv
// payload decode: http method, http status line and dns header checks
module lt7_sniff (
   input  logic [63:0]            head_low,
   input  logic [63:0]            head_high,
   output lt7_pkg::lt7_sniff_type sniff
);
   import lt7_pkg::*;

   logic [7:0] b [16];
   logic       dig9, dig10, dig11, dig5, dig7;
   logic [3:0] d9, d10, d11;

   // byte split
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         b[k]     = head_low[8*k +: 8];
         b[k + 8] = head_high[8*k +: 8];
      end
   end

   assign dig5  = (b[5]  >= "0") && (b[5]  <= "9");
   assign dig7  = (b[7]  >= "0") && (b[7]  <= "9");
   assign dig9  = (b[9]  >= "0") && (b[9]  <= "9");
   assign dig10 = (b[10] >= "0") && (b[10] <= "9");
   assign dig11 = (b[11] >= "0") && (b[11] <= "9");
   assign d9    = 4'(b[9]  - "0");
   assign d10   = 4'(b[10] - "0");
   assign d11   = 4'(b[11] - "0");

   always_comb begin
      // http methods
      sniff.http_req =
         (b[0] == "G" && b[1] == "E" && b[2] == "T") ||
         (b[0] == "P" && b[1] == "O" && b[2] == "S" && b[3] == "T") ||
         (b[0] == "H" && b[1] == "E" && b[2] == "A" && b[3] == "D") ||
         (b[0] == "P" && b[1] == "U" && b[2] == "T") ||
         (b[0] == "D" && b[1] == "E" && b[2] == "L" && b[3] == "E" &&
          b[4] == "T" && b[5] == "E") ||
         (b[0] == "O" && b[1] == "P" && b[2] == "T" && b[3] == "I" &&
          b[4] == "O" && b[5] == "N" && b[6] == "S") ||
         (b[0] == "P" && b[1] == "A" && b[2] == "T" && b[3] == "C" && b[4] == "H");
      // status line
      sniff.http_resp =
         b[0] == "H" && b[1] == "T" && b[2] == "T" && b[3] == "P" && b[4] == "/" &&
         dig5 && b[6] == "." && dig7 && b[8] == " " && dig9 && dig10 && dig11;
      sniff.http_status = 10'(d9) * 10'd100 + 10'(d10) * 10'd10 + 10'(d11);
      // dns header, query and response differ only in the qr bit
      sniff.dns_query = ((b[2] & QR_BIT) == 8'd0) && ((b[2] & OPCODE_BITS) == 8'd0) &&
                        (b[4] == 8'd0) && (b[5] == 8'd1);
      sniff.dns_resp  = ((b[2] & QR_BIT) != 8'd0) && ((b[2] & OPCODE_BITS) == 8'd0) &&
                        (b[4] == 8'd0) && (b[5] == 8'd1);
      sniff.txn       = {b[0], b[1]};
      sniff.rcode     = 4'(b[3] & RCODE_BITS);
   end

endmodule

>>> design/l7_request_response_latency_tracker_core.sv
// top level of the layer-7 request/response latency tracker
// Each accepted request (a syscall event) passes through a lookup state and an update
// state: in the lookup state, the key is compared in every cell of the request table
// and the destination table, and the hit entry's word and age travel along each row
// of cells into a register; in the update state, the payload is decoded and every
// cell applies the write, lru touch or retire broadcast to it, and a matched response
// is loaded into the output register. A new request is taken in that update state,
// so requests overlap; a result that finds the output register still full holds the
// block until it is taken. Both tables are fully associative with exact lru ages
// kept in the cells.
module l7_request_response_latency_tracker_core #(
   parameter int REQ_ENTRIES = 64,
   parameter int DST_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // proc_id, file_desc, length, head_low, head_high, now_ns, dest_ipv4,
   // dest_port_in, dest_is_ipv4, zero fill
   input  logic [343:0] req_tdata,
   // command
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_proc_id, out_file_desc, status, latency_ns, out_dest_addr, out_dest_port,
   // request_bytes, response_bytes, zero fill
   output logic [207:0] rsp_tdata,
   // protocol
   output logic         rsp_tuser
);
   import lt7_pkg::*;

   localparam int RW = $clog2(REQ_ENTRIES);
   localparam int DW = $clog2(DST_ENTRIES);
   localparam logic [RW-1:0] REQ_LAST = RW'(REQ_ENTRIES - 1);
   localparam logic [DW-1:0] DST_LAST = DW'(DST_ENTRIES - 1);

   lt7_state_type state_ff, state_in;

   // request item register
   logic [1:0]   cmd_ff;
   logic [343:0] item_ff;
   logic [63:0]  key;
   logic [31:0]  len;
   logic [63:0]  now;
   logic         has_dst;
   logic         long_enough;

   assign key         = {item_ff[31:0], item_ff[63:32]};
   assign len         = item_ff[95:64];
   assign now         = item_ff[287:224];
   assign has_dst     = item_ff[336];
   assign long_enough = (len >= MIN_SNIFF);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff  <= req_tuser;
         item_ff <= req_tdata;
      end
   end

   // cell rows
   lt7_op_type           req_op, dst_op;
   logic [RW-1:0]        req_tgt;
   logic [DW-1:0]        dst_tgt;
   logic [REQ_DATA_W-1:0] req_wdata;
   logic [DST_DATA_W-1:0] dst_wdata;

   logic                  req_hc [REQ_ENTRIES+1];
   logic [RW-1:0]         req_ac [REQ_ENTRIES+1];
   logic [REQ_DATA_W-1:0] req_dc [REQ_ENTRIES+1];
   logic                  dst_hc [DST_ENTRIES+1];
   logic [DW-1:0]         dst_ac [DST_ENTRIES+1];
   logic [DST_DATA_W-1:0] dst_dc [DST_ENTRIES+1];

   assign req_hc[0] = 1'b0;
   assign req_ac[0] = '0;
   assign req_dc[0] = '0;
   assign dst_hc[0] = 1'b0;
   assign dst_ac[0] = '0;
   assign dst_dc[0] = '0;

   for (genvar i = 0; i < REQ_ENTRIES; i++) begin : g_req
      lt7_cell #(.ENTRIES(REQ_ENTRIES), .INDEX(i), .DATA_W(REQ_DATA_W)) u_cell (
         .clock, .reset, .op_i(req_op), .tgt_age_i(req_tgt), .key_i(key),
         .wdata_i(req_wdata), .hit_in(req_hc[i]), .age_in(req_ac[i]),
         .data_in(req_dc[i]), .hit_out(req_hc[i+1]), .age_out(req_ac[i+1]),
         .data_out(req_dc[i+1]));
   end

   for (genvar i = 0; i < DST_ENTRIES; i++) begin : g_dst
      lt7_cell #(.ENTRIES(DST_ENTRIES), .INDEX(i), .DATA_W(DST_DATA_W)) u_cell (
         .clock, .reset, .op_i(dst_op), .tgt_age_i(dst_tgt), .key_i(key),
         .wdata_i(dst_wdata), .hit_in(dst_hc[i]), .age_in(dst_ac[i]),
         .data_in(dst_dc[i]), .hit_out(dst_hc[i+1]), .age_out(dst_ac[i+1]),
         .data_out(dst_dc[i+1]));
   end

   // lookup results
   logic                  req_hit_ff, dst_hit_ff;
   logic [RW-1:0]         req_age_ff;
   logic [DW-1:0]         dst_age_ff;
   logic [REQ_DATA_W-1:0] req_rd_ff;
   logic [DST_DATA_W-1:0] dst_rd_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         req_hit_ff <= req_hc[REQ_ENTRIES];
         req_age_ff <= req_ac[REQ_ENTRIES];
         req_rd_ff  <= req_dc[REQ_ENTRIES];
         dst_hit_ff <= dst_hc[DST_ENTRIES];
         dst_age_ff <= dst_ac[DST_ENTRIES];
         dst_rd_ff  <= dst_dc[DST_ENTRIES];
      end
   end

   // payload decode
   lt7_sniff_type sniff;

   lt7_sniff u_sniff (
      .head_low(item_ff[159:96]), .head_high(item_ff[223:160]), .sniff(sniff));

   // match against the stored request
   logic        st_proto;
   logic [15:0] st_txn;
   logic [LEN_W-1:0] st_len;
   logic [63:0] st_time;
   logic        matched, result, upd_done, is_req, is_rsp, is_conn;
   logic [9:0]  status;

   assign st_time  = req_rd_ff[RD_TIME_LO +: 64];
   assign st_proto = req_rd_ff[RD_PROTO];
   assign st_txn   = req_rd_ff[RD_TXN_LO +: 16];
   assign st_len   = req_rd_ff[RD_LEN_LO +: LEN_W];
   assign is_req   = (cmd_ff == CMD_REQUEST);
   assign is_rsp   = (cmd_ff == CMD_RESPONSE);
   assign is_conn  = (cmd_ff == CMD_CONNECT);
   assign matched  = (st_proto == PROTO_HTTP) ? sniff.http_resp
                                              : (sniff.dns_resp && sniff.txn == st_txn);
   assign status   = (st_proto == PROTO_HTTP) ? sniff.http_status : 10'(sniff.rcode);
   assign result   = (state_ff == ST_UPDATE) && is_rsp && long_enough && req_hit_ff &&
                     matched;
   assign upd_done = !(result && rsp_tvalid && !rsp_tready);

   // table write words
   assign req_wdata = {len[LEN_W-1:0], (sniff.http_req ? 16'd0 : sniff.txn),
                       (sniff.http_req ? PROTO_HTTP : PROTO_DNS), now};
   assign dst_wdata = {item_ff[335:320], item_ff[319:288]};

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // sequencing and cell commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      req_op     = OP_NONE;
      dst_op     = OP_NONE;
      req_tgt    = req_age_ff;
      dst_tgt    = dst_age_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_done) begin
               req_tready = 1'b1;
               state_in   = req_tvalid ? ST_LOOK : ST_IDLE;
               // destination table
               if ((is_req || is_conn) && has_dst) begin
                  dst_op  = OP_WRITE;
                  dst_tgt = dst_hit_ff ? dst_age_ff : DST_LAST;
               end else if (result && dst_hit_ff) begin
                  dst_op = OP_TOUCH;
               end
               // request table
               if (is_req && long_enough && (sniff.http_req || sniff.dns_query)) begin
                  req_op  = OP_WRITE;
                  req_tgt = req_hit_ff ? req_age_ff : REQ_LAST;
               end else if (is_rsp && long_enough && req_hit_ff) begin
                  req_op = matched ? OP_RETIRE : OP_TOUCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   logic         rsp_valid_ff;
   logic [207:0] rsp_data_ff;
   logic         rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result && upd_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result && upd_done) begin
         rsp_user_ff <= st_proto;
         rsp_data_ff <= {4'd0, len[LEN_W-1:0], st_len,
                         (dst_hit_ff ? dst_rd_ff[47:32] : 16'd0),
                         (dst_hit_ff ? dst_rd_ff[31:0] : 32'd0),
                         now - st_time, status, item_ff[63:32], item_ff[31:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> design/lt7_checker.sv
// port-level checks of the latency tracker, bound to the top level
module lt7_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);
   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // the lookup cycle after a request takes no new request
   a_look_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during lookup");

   // a new result follows an accepted request through the lookup and update states
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result without a request");

   // reset empties the output
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");
endmodule

bind l7_request_response_latency_tracker_core lt7_checker u_lt7_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready));
